// ----- hw/rtl/periodic_timer_table_unit_macros.svh -----
// Assertion macros shared by the timer table RTL.
`ifndef PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH
`define PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PTT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table sequencing check failed");

`endif

// ----- hw/rtl/ptt_pkg.sv -----
package ptt_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDXW        = $clog2(SLOTS);
  localparam int CNTW        = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_STOP   = 2'd3;

  localparam logic [2:0] KIND_ADDED     = 3'd0;
  localparam logic [2:0] KIND_REFUSED   = 3'd1;
  localparam logic [2:0] KIND_REMOVED   = 3'd2;
  localparam logic [2:0] KIND_NOTFOUND  = 3'd3;
  localparam logic [2:0] KIND_EXPIRED   = 3'd4;
  localparam logic [2:0] KIND_DESTROYED = 3'd5;
  localparam logic [2:0] KIND_NOTHING   = 3'd6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  user_id;
    logic [15:0] delay;
    logic [15:0] period;
  } in_data_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] user_out;
    logic       last;
  } out_data_t;

  typedef struct packed {
    logic [7:0]  user;
    logic [31:0] deadline;
    logic [15:0] period;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

// ----- hw/rtl/ptt_ram.sv -----
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/periodic_timer_table_unit.sv -----
// Periodic timer table: a set of timer slots kept in a one-port-read,
// one-port-write RAM, with slot valid bits in flip-flops.
// Input channel (in_valid/in_ready/in_data) takes one command per transfer:
// add, remove user, tick or stop. Results leave on out_valid/out_ready/
// out_data, one or more per command, the final one flagged by last.
// An add is decided in the accept cycle and its result waits in the hold stage
// until the FLUSH state moves it to the output register; then the next command can be taken.
// Remove, tick and stop sweep every slot through the RAM, one slot per cycle
// while no report stalls, each slot's word read through the registered RAM
// read port; the final result then goes from FLUSH into the output register, and
// the next command is taken once FLUSH has handed that result on.
// The sweep is paced by the single RAM read port.
// Results pass through a one-entry hold stage and an output register, so
// when the receiver stalls the sweep pauses on the slot that wants to report
// and resumes once the output register drains; nothing is dropped.
// A new command may be accepted while the final result of the previous one
// still waits in the output register.
// Reset (rst_n low, synchronous) empties the table, zeroes the tick counter
// and puts the table in the running state; RAM contents need no clearing.
module periodic_timer_table_unit
  import ptt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_data_t out_data
);

  `include "periodic_timer_table_unit_macros.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [31:0]     now_r, now_nxt;
  logic            running_r, running_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [7:0]      user_r, user_nxt;
  logic            found_r, found_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [IDXW-1:0] scan_idx_r, scan_idx_nxt;
  logic            issue_done_r, issue_done_nxt;
  logic            s1_vld_r, s1_vld_nxt;
  logic [IDXW-1:0] s1_idx_r, s1_idx_nxt;
  logic            pend_vld_r, pend_vld_nxt;
  logic [2:0]      pend_kind_r, pend_kind_nxt;
  logic [7:0]      pend_user_r, pend_user_nxt;
  logic            out_vld_r, out_vld_nxt;
  out_data_t       out_data_r, out_data_nxt;

  logic            in_fire;
  logic            out_ok;
  logic            has_free;
  logic [IDXW-1:0] free_idx;
  logic            wr_en;
  logic [IDXW-1:0] wr_addr;
  slot_t           wr_data;
  logic            rd_en;
  slot_t           rd_data;
  logic [31:0]     age;
  logic            slot_live;
  logic            emit_req;
  logic [2:0]      emit_kind;
  logic            stall;
  logic            advance;

  ptt_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(scan_idx_r),
    .rd_data(rd_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_ok    = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Lowest free slot.
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = IDXW'(i);
      end
    end
  end

  // Evaluation of the slot whose RAM word is on rd_data.
  assign age       = now_r - rd_data.deadline;
  assign slot_live = s1_vld_r && valid_r[s1_idx_r] && (cnt_r < CNTW'(MAX_RESULTS));

  always_comb begin
    emit_req  = 1'b0;
    emit_kind = KIND_EXPIRED;
    if (state_r == ST_SCAN && slot_live) begin
      if (op_r == MODE_TICK && !age[31]) begin
        emit_req = 1'b1;
      end else if (op_r == MODE_STOP) begin
        emit_req  = 1'b1;
        emit_kind = KIND_DESTROYED;
      end
    end
  end

  // A report must wait when the hold stage is full and cannot drain.
  assign stall   = emit_req && pend_vld_r && !out_ok;
  assign advance = (state_r == ST_SCAN) && !stall;
  assign rd_en   = advance && !issue_done_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = free_idx;
    wr_data = rd_data;
    if (in_fire && in_data.mode == MODE_ADD && running_r && has_free) begin
      wr_en            = 1'b1;
      wr_data.user     = in_data.user_id;
      wr_data.deadline = now_r + {16'd0, in_data.delay};
      wr_data.period   = in_data.period;
    end else if (advance && emit_req && op_r == MODE_TICK && rd_data.period != 16'd0) begin
      wr_en            = 1'b1;
      wr_addr          = s1_idx_r;
      wr_data.deadline = now_r + {16'd0, rd_data.period};
    end
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    now_nxt        = now_r;
    running_nxt    = running_r;
    op_nxt         = op_r;
    user_nxt       = user_r;
    found_nxt      = found_r;
    cnt_nxt        = cnt_r;
    scan_idx_nxt   = scan_idx_r;
    issue_done_nxt = issue_done_r;
    s1_vld_nxt     = s1_vld_r;
    s1_idx_nxt     = s1_idx_r;
    pend_vld_nxt   = pend_vld_r;
    pend_kind_nxt  = pend_kind_r;
    pend_user_nxt  = pend_user_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_data.mode;
          user_nxt       = in_data.user_id;
          found_nxt      = 1'b0;
          cnt_nxt        = '0;
          scan_idx_nxt   = '0;
          issue_done_nxt = 1'b0;
          s1_vld_nxt     = 1'b0;
          if (in_data.mode == MODE_ADD) begin
            pend_vld_nxt  = 1'b1;
            pend_user_nxt = in_data.user_id;
            if (running_r && has_free) begin
              pend_kind_nxt       = KIND_ADDED;
              valid_nxt[free_idx] = 1'b1;
            end else begin
              pend_kind_nxt = KIND_REFUSED;
            end
            state_nxt = ST_FLUSH;
          end else begin
            if (in_data.mode == MODE_TICK) begin
              now_nxt = now_r + 32'd1;
            end
            if (in_data.mode == MODE_STOP) begin
              running_nxt = 1'b0;
            end
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (advance) begin
          if (s1_vld_r && valid_r[s1_idx_r]) begin
            case (op_r)
              MODE_REMOVE: begin
                if (rd_data.user == user_r) begin
                  valid_nxt[s1_idx_r] = 1'b0;
                  found_nxt           = 1'b1;
                end
              end
              MODE_TICK: begin
                if (emit_req && rd_data.period == 16'd0) begin
                  valid_nxt[s1_idx_r] = 1'b0;
                end
              end
              MODE_STOP: begin
                valid_nxt[s1_idx_r] = 1'b0;
              end
              default: begin
              end
            endcase
          end
          if (emit_req) begin
            // The previous report is now known not to be the final one.
            if (pend_vld_r) begin
              out_vld_nxt           = 1'b1;
              out_data_nxt.kind     = pend_kind_r;
              out_data_nxt.user_out = pend_user_r;
              out_data_nxt.last     = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_kind_nxt = emit_kind;
            pend_user_nxt = rd_data.user;
            cnt_nxt       = cnt_r + CNTW'(1);
          end
          s1_vld_nxt = !issue_done_r;
          s1_idx_nxt = scan_idx_r;
          if (!issue_done_r) begin
            if (scan_idx_r == IDXW'(SLOTS - 1)) begin
              issue_done_nxt = 1'b1;
            end else begin
              scan_idx_nxt = scan_idx_r + IDXW'(1);
            end
          end
          if (s1_vld_r && s1_idx_r == IDXW'(SLOTS - 1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_ok) begin
          out_vld_nxt       = 1'b1;
          out_data_nxt.last = 1'b1;
          if (pend_vld_r) begin
            out_data_nxt.kind     = pend_kind_r;
            out_data_nxt.user_out = pend_user_r;
          end else if (op_r == MODE_REMOVE) begin
            out_data_nxt.kind     = found_r ? KIND_REMOVED : KIND_NOTFOUND;
            out_data_nxt.user_out = user_r;
          end else begin
            out_data_nxt.kind     = KIND_NOTHING;
            out_data_nxt.user_out = 8'd0;
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      now_r        <= '0;
      running_r    <= 1'b1;
      found_r      <= 1'b0;
      cnt_r        <= '0;
      scan_idx_r   <= '0;
      issue_done_r <= 1'b0;
      s1_vld_r     <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
      op_r         <= MODE_ADD;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      now_r        <= now_nxt;
      running_r    <= running_nxt;
      found_r      <= found_nxt;
      cnt_r        <= cnt_nxt;
      scan_idx_r   <= scan_idx_nxt;
      issue_done_r <= issue_done_nxt;
      s1_vld_r     <= s1_vld_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      op_r         <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    user_r      <= user_nxt;
    s1_idx_r    <= s1_idx_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_user_r <= pend_user_nxt;
    out_data_r  <= out_data_nxt;
  end

  `PTT_ASSERT_IMPL(a_hold_empty_when_idle, state_r == ST_IDLE, !pend_vld_r)
  `PTT_ASSERT_IMPL(a_stopped_table_empty, !running_r && state_r == ST_IDLE, valid_r == '0)
  `PTT_ASSERT_IMPL(a_report_count_bounded, 1'b1, cnt_r <= CNTW'(MAX_RESULTS))
  `PTT_ASSERT_NEXT(a_stall_holds_slot, stall, s1_vld_r && $stable(s1_idx_r))

endmodule

// ----- verif/tb_periodic_timer_table_unit.sv -----
module tb_periodic_timer_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int MAX_SHOWN    = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_data_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_data_t out_data;

  // Expected timer table contents, kept in step with accepted commands.
  logic        live     [SLOTS];
  logic [7:0]  owner    [SLOTS];
  logic [31:0] deadline [SLOTS];
  logic [15:0] reload   [SLOTS];
  logic [31:0] tick_count;
  logic        accepting;
  out_data_t   awaited_reports [$];

  int send_idle_pct  = 16;
  int recv_idle_pct  = 55;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int stall_cycles   = 0;
  int mismatch_count = 0;

  periodic_timer_table_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic in_data_t make_cmd(input logic [1:0] mode, input logic [7:0] user,
                                        input logic [15:0] delay, input logic [15:0] period);
    in_data_t cmd;
    cmd.mode    = mode;
    cmd.user_id = user;
    cmd.delay   = delay;
    cmd.period  = period;
    return cmd;
  endfunction

  // Updates the expected table for one command and queues the reports it causes.
  function automatic void compute_reports(input in_data_t cmd);
    out_data_t   rep [MAX_RESULTS];
    int          n;
    int          i;
    int          slot;
    bit          hit;
    logic [31:0] age;
    n    = 0;
    slot = -1;
    hit  = 1'b0;
    case (cmd.mode)
      MODE_ADD: begin
        if (accepting) begin
          for (i = SLOTS - 1; i >= 0; i--) begin
            if (!live[i]) slot = i;
          end
        end
        if (slot < 0) begin
          rep[n] = '{KIND_REFUSED, cmd.user_id, 1'b0};
        end else begin
          live[slot]     = 1'b1;
          owner[slot]    = cmd.user_id;
          deadline[slot] = tick_count + {16'd0, cmd.delay};
          reload[slot]   = cmd.period;
          rep[n] = '{KIND_ADDED, cmd.user_id, 1'b0};
        end
        n++;
      end
      MODE_REMOVE: begin
        if (accepting) begin
          for (i = 0; i < SLOTS; i++) begin
            if (live[i] && owner[i] == cmd.user_id) begin
              live[i] = 1'b0;
              hit     = 1'b1;
            end
          end
        end
        rep[n] = '{hit ? KIND_REMOVED : KIND_NOTFOUND, cmd.user_id, 1'b0};
        n++;
      end
      MODE_TICK: begin
        tick_count = tick_count + 32'd1;
        if (accepting) begin
          for (i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
            if (live[i]) begin
              // A slot is due when the time since its deadline is "non-negative"
              // in wraparound arithmetic.
              age = tick_count - deadline[i];
              if (!age[31]) begin
                rep[n] = '{KIND_EXPIRED, owner[i], 1'b0};
                n++;
                if (reload[i] != 16'd0) deadline[i] = tick_count + {16'd0, reload[i]};
                else live[i] = 1'b0;
              end
            end
          end
        end
      end
      MODE_STOP: begin
        for (i = 0; i < SLOTS; i++) begin
          if (live[i] && n < MAX_RESULTS) begin
            rep[n] = '{KIND_DESTROYED, owner[i], 1'b0};
            n++;
          end
          live[i] = 1'b0;
        end
        accepting = 1'b0;
      end
    endcase
    if (n == 0) begin
      rep[0] = '{KIND_NOTHING, 8'd0, 1'b0};
      n = 1;
    end
    rep[n-1].last = 1'b1;
    for (i = 0; i < n; i++) awaited_reports.push_back(rep[i]);
  endfunction

  // Offers one command, holding it until the transfer, then predicts its reports.
  task automatic issue_cmd(input in_data_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_reports(cmd);
  endtask

  task automatic wait_reports_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    issue_cmd(make_cmd(MODE_TICK, 8'h00, 16'h0000, 16'h0000));
    issue_cmd(make_cmd(MODE_REMOVE, 8'h00, 16'h0000, 16'h0000));
    // Zero delay makes this one-shot slot due on the very next tick.
    issue_cmd(make_cmd(MODE_ADD, 8'h00, 16'h0000, 16'h0000));
    issue_cmd(make_cmd(MODE_ADD, 8'hFF, 16'hFFFF, 16'hFFFF));
    issue_cmd(make_cmd(MODE_ADD, 8'hA5, 16'h0001, 16'h0002));
    repeat (4) issue_cmd(make_cmd(MODE_TICK, 8'h5A, 16'h5A5A, 16'hA5A5));
    issue_cmd(make_cmd(MODE_REMOVE, 8'hFF, 16'h0000, 16'h0000));
    issue_cmd(make_cmd(MODE_REMOVE, 8'hFF, 16'h0000, 16'h0000));
    // The freed lowest slot is reused, leaving two slots owned by the same user.
    issue_cmd(make_cmd(MODE_ADD, 8'hA5, 16'h0003, 16'h0000));
    issue_cmd(make_cmd(MODE_REMOVE, 8'hA5, 16'hFFFF, 16'hFFFF));
    wait_reports_done();
  endtask

  // The receiver stalls while the table is filled, so results pile up and the
  // input channel backs up; then a full tick reports every slot at once.
  task automatic test_backpressure();
    int         i;
    logic [7:0] user;
    hold_requests <= hold_requests + 1;
    for (i = 0; i < SLOTS; i++) begin
      user = 8'h10 + i[7:0];
      issue_cmd(make_cmd(MODE_ADD, user, 16'd0, {15'd0, i[0]}));
    end
    issue_cmd(make_cmd(MODE_ADD, 8'h77, 16'd5, 16'd5));
    issue_cmd(make_cmd(MODE_TICK, 8'h00, 16'd0, 16'd0));
    issue_cmd(make_cmd(MODE_TICK, 8'h00, 16'd0, 16'd0));
    wait_reports_done();
  endtask

  task automatic test_random_traffic(input int count);
    int          k;
    int          pick;
    int          r;
    int          slot;
    logic [1:0]  mode;
    logic [7:0]  user;
    logic [15:0] delay;
    logic [15:0] period;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      // Mostly a small pool of users so that removes find something.
      if ($urandom_range(3) == 0) user = 8'($urandom_range(255));
      else user = 8'($urandom_range(7));
      r = $urandom_range(19);
      if (r == 0) delay = 16'($urandom);
      else if (r < 4) delay = 16'($urandom_range(300));
      else delay = 16'($urandom_range(20));
      r = $urandom_range(19);
      if (r < 8) period = 16'd0;
      else if (r < 17) period = 16'($urandom_range(20, 1));
      else period = 16'($urandom);
      if (pick < 40) begin
        mode = MODE_ADD;
      end else if (pick < 62) begin
        mode = MODE_REMOVE;
        slot = $urandom_range(SLOTS - 1);
        if ($urandom_range(1) == 1 && live[slot]) user = owner[slot];
      end else begin
        mode = MODE_TICK;
      end
      issue_cmd(make_cmd(mode, user, delay, period));
    end
  endtask

  // Stop is final, so this runs last: it fills the table, destroys it and
  // checks that every later command is answered as stopped.
  task automatic test_stop();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (!live[i]) begin
        issue_cmd(make_cmd(MODE_ADD, 8'($urandom_range(255)),
                           16'($urandom_range(65535, 40000)), 16'($urandom)));
      end
    end
    issue_cmd(make_cmd(MODE_ADD, 8'h3C, 16'd1, 16'd0));
    issue_cmd(make_cmd(MODE_STOP, 8'h00, 16'd0, 16'd0));
    issue_cmd(make_cmd(MODE_STOP, 8'hFF, 16'hFFFF, 16'hFFFF));
    issue_cmd(make_cmd(MODE_ADD, 8'h3C, 16'd0, 16'd0));
    issue_cmd(make_cmd(MODE_REMOVE, 8'h3C, 16'd0, 16'd0));
    issue_cmd(make_cmd(MODE_TICK, 8'h00, 16'd0, 16'd0));
    wait_reports_done();
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_data_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
          $display("%0t: unexpected result kind=%0d user=%0d last=%0d",
                   $realtime, out_data.kind, out_data.user_out, out_data.last);
        end
      end else begin
        want = awaited_reports.pop_front();
        if (out_data.kind !== want.kind || out_data.user_out !== want.user_out ||
            out_data.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display("%0t: expected kind=%0d user=%0d last=%0d, got kind=%0d user=%0d last=%0d",
                     $realtime, want.kind, want.user_out, want.last,
                     out_data.kind, out_data.user_out, out_data.last);
          end
        end
      end
    end
  end

  // Counts cycles without any transfer while work is outstanding.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && awaited_reports.size() == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      live[i]     = 1'b0;
      owner[i]    = '0;
      deadline[i] = '0;
      reload[i]   = '0;
    end
    tick_count = '0;
    accepting  = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_traffic(110);
    send_idle_pct = 55;
    recv_idle_pct <= 16;
    test_random_traffic(110);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_random_traffic(100);
    test_stop();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
